// File: design/assert_macros.svh
// assertion macros used by the board notation parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

// File: design/bnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnp_pkg
// types, constants and helpers for the board notation parser
// ----------------------------------------------------------------------------
package bnp_pkg;

  localparam int COLUMNS = 9;
  localparam int ROWS    = 10;

  localparam logic [3:0] COL_LIMIT = 4'(COLUMNS);
  localparam logic [3:0] ROW_LAST  = 4'(ROWS - 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_K     = 8'h6B;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [2:0] PIECE_CHARIOT  = 3'd0;
  localparam logic [2:0] PIECE_HORSE    = 3'd1;
  localparam logic [2:0] PIECE_ELEPHANT = 3'd2;
  localparam logic [2:0] PIECE_ADVISOR  = 3'd3;
  localparam logic [2:0] PIECE_KING     = 3'd4;
  localparam logic [2:0] PIECE_CANNON   = 3'd5;
  localparam logic [2:0] PIECE_SOLDIER  = 3'd6;
  localparam logic [2:0] PIECE_NONE     = 3'd7;

  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_BOARD = 3'd1,
    PH_GAP   = 3'd2,
    PH_TURN  = 3'd3,
    PH_TAIL  = 3'd4
  } phase_t;

  typedef struct packed {
    logic       has;
    logic       kind;
    logic [3:0] rank_row;
    logic [3:0] file_col;
    logic [2:0] piece;
    logic       piece_red;
    logic       valid_res;
    logic       red_to_move;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [2:0] piece_of(input logic [7:0] lc);
    logic [2:0] p;
    case (lc)
      CH_R:    p = PIECE_CHARIOT;
      CH_N:    p = PIECE_HORSE;
      CH_LB:   p = PIECE_ELEPHANT;
      CH_A:    p = PIECE_ADVISOR;
      CH_K:    p = PIECE_KING;
      CH_C:    p = PIECE_CANNON;
      CH_P:    p = PIECE_SOLDIER;
      default: p = PIECE_NONE;
    endcase
    return p;
  endfunction

endpackage

// File: design/bnp_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnp_parser_core
// parse state register and the per-byte step logic
// ----------------------------------------------------------------------------
module bnp_parser_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_code,
  input  logic                 last,
  output bnp_pkg::result_t     res
);

  bnp_pkg::phase_t phase, phase_next;
  logic [3:0] row_pos, row_pos_next;
  logic [3:0] col_pos, col_pos_next;
  logic       failed, failed_next;
  logic [1:0] turn_length, turn_length_next;
  logic       turn_is_red, turn_is_red_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bnp_pkg::PH_LEAD;
      row_pos     <= '0;
      col_pos     <= '0;
      failed      <= 1'b0;
      turn_length <= '0;
      turn_is_red <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      row_pos     <= row_pos_next;
      col_pos     <= col_pos_next;
      failed      <= failed_next;
      turn_length <= turn_length_next;
      turn_is_red <= turn_is_red_next;
    end
  end

  always_comb begin
    logic       blank;
    logic       placed;
    logic       up;
    logic [7:0] lc;
    logic [2:0] code;
    logic [4:0] nc;
    logic       ok;

    blank            = bnp_pkg::is_blank(char_code);
    placed           = 1'b0;
    up               = char_code inside {[bnp_pkg::CH_UP_A:bnp_pkg::CH_UP_Z]};
    lc               = up ? (char_code | 8'h20) : char_code;
    code             = bnp_pkg::piece_of(lc);
    nc               = {1'b0, col_pos} + {1'b0, char_code[3:0]};
    phase_next       = phase;
    row_pos_next     = row_pos;
    col_pos_next     = col_pos;
    failed_next      = failed;
    turn_length_next = turn_length;
    turn_is_red_next = turn_is_red;

    if (!failed) begin
      if (phase_next == bnp_pkg::PH_LEAD && !blank) begin
        phase_next = bnp_pkg::PH_BOARD;
      end
      if (phase_next == bnp_pkg::PH_BOARD) begin
        if (blank) begin
          if (row_pos != bnp_pkg::ROW_LAST || col_pos != bnp_pkg::COL_LIMIT) begin
            failed_next = 1'b1;
          end
          phase_next = bnp_pkg::PH_GAP;
        end else if (char_code == bnp_pkg::CH_SLASH) begin
          if (col_pos != bnp_pkg::COL_LIMIT || row_pos >= bnp_pkg::ROW_LAST) begin
            failed_next = 1'b1;
          end else begin
            row_pos_next = row_pos + 4'd1;
            col_pos_next = '0;
          end
        end else if (row_pos > bnp_pkg::ROW_LAST) begin
          failed_next = 1'b1;
        end else if (char_code inside {[bnp_pkg::CH_ONE:bnp_pkg::CH_NINE]}) begin
          if (nc > {1'b0, bnp_pkg::COL_LIMIT}) begin
            failed_next = 1'b1;
          end else begin
            col_pos_next = nc[3:0];
          end
        end else if (col_pos >= bnp_pkg::COL_LIMIT) begin
          failed_next = 1'b1;
        end else if (code == bnp_pkg::PIECE_NONE) begin
          failed_next = 1'b1;
        end else begin
          placed       = 1'b1;
          col_pos_next = col_pos + 4'd1;
        end
      end else if (phase_next == bnp_pkg::PH_GAP) begin
        if (!blank) begin
          phase_next = bnp_pkg::PH_TURN;
        end
      end
      if (phase_next == bnp_pkg::PH_TURN && !failed_next) begin
        if (blank) begin
          phase_next = bnp_pkg::PH_TAIL;
        end else if (turn_length == 2'd0) begin
          turn_is_red_next = (char_code == bnp_pkg::CH_W);
          if (char_code != bnp_pkg::CH_W && char_code != bnp_pkg::CH_B) begin
            failed_next = 1'b1;
          end
          turn_length_next = 2'd1;
        end else begin
          failed_next      = 1'b1;
          turn_length_next = 2'd2;
        end
      end
    end

    ok = !failed_next && turn_length_next == 2'd1 &&
         (phase_next == bnp_pkg::PH_TURN || phase_next == bnp_pkg::PH_TAIL);

    res = '0;
    if (last) begin
      res.has          = 1'b1;
      res.kind         = bnp_pkg::KIND_STATUS;
      res.valid_res    = ok;
      res.red_to_move  = ok && turn_is_red_next;
      // text done, parse state back to reset
      phase_next       = bnp_pkg::PH_LEAD;
      row_pos_next     = '0;
      col_pos_next     = '0;
      failed_next      = 1'b0;
      turn_length_next = '0;
      turn_is_red_next = 1'b0;
    end else if (placed && !failed_next) begin
      res.has       = 1'b1;
      res.kind      = bnp_pkg::KIND_PLACE;
      res.rank_row  = row_pos;
      res.file_col  = col_pos;
      res.piece     = code;
      res.piece_red = up;
    end
  end

endmodule

// File: design/board_notation_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// board_notation_parser
// streaming parser for a xiangqi board position text
// ----------------------------------------------------------------------------
// Takes one byte of position text per word and accepts a new word every
// cycle while no result word waits on m_tready. Each word passes an input
// register, the parse logic against the held parse state, and a result
// register that holds the result word until taken. A piece byte yields a
// placement word (tuser 0); the byte marked tlast yields a status word
// (tuser 1) and returns the parser to its reset state for the next text.
// Bytes that produce no result are consumed without output. No clearing pass
// is needed after reset.
module board_notation_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  // rank_row[3:0], file_col[7:4], piece[10:8], piece_red[11],
  // valid_res[12], red_to_move[13], zero fill[15:14]
  output logic [15:0] m_tdata,
  output logic [0:0]  m_tuser    // kind
);

  `include "assert_macros.svh"

  logic              in_valid;
  logic [7:0]        in_char;
  logic              in_last;
  logic              advance;
  bnp_pkg::result_t  res;
  logic              out_valid;
  bnp_pkg::result_t  out_res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  bnp_parser_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (in_char),
    .last      (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.has;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has) begin
      out_res <= res;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tuser[0] = out_res.kind;
  assign m_tdata    = {2'b00, out_res.red_to_move, out_res.valid_res, out_res.piece_red,
                       out_res.piece, out_res.file_col, out_res.rank_row};

  // placements carry no status bits and stay on the board
  `ASSERT_PROP(a_place_fields, clk, rst,
    (out_valid && out_res.kind == bnp_pkg::KIND_PLACE) |->
      (!out_res.valid_res && !out_res.red_to_move &&
       out_res.rank_row <= bnp_pkg::ROW_LAST && out_res.file_col < bnp_pkg::COL_LIMIT &&
       out_res.piece != bnp_pkg::PIECE_NONE))
  `ASSERT_PROP(a_turn_needs_valid, clk, rst,
    (out_valid && out_res.kind == bnp_pkg::KIND_STATUS && out_res.red_to_move) |->
      out_res.valid_res)
  `ASSERT_PROP(a_ready_when_empty, clk, rst, !out_valid |-> s_tready)

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the board notation parser
// ----------------------------------------------------------------------------
// Feeds position texts one byte per word: first a short table of directed
// bytes, then random texts that are mostly complete boards with a side to
// move, mixed with corrupted, truncated and noisy texts. A behavioral parser
// in the bench predicts every untyped placement and status word. Words are
// compared field by field in order, with random idling on both sides.
module testbench;

  localparam int TARGET_BYTES = 1300;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    logic             typed;
    bnp_pkg::result_t fixed;
  } stim_row_t;

  localparam bnp_pkg::result_t NO_RESULT  = '0;
  localparam bnp_pkg::result_t STATUS_BAD =
    '{has: 1'b1, kind: bnp_pkg::KIND_STATUS, default: '0};

  localparam logic [7:0] PIECE_LETTERS [7] = '{bnp_pkg::CH_R, bnp_pkg::CH_N, bnp_pkg::CH_LB,
                                              bnp_pkg::CH_A, bnp_pkg::CH_K, bnp_pkg::CH_C,
                                              bnp_pkg::CH_P};

  // typed rows carry their word, the others go through the parser model
  localparam stim_row_t DIRECTED [21] = '{
    '{8'h09,             1'b0, 1'b1, NO_RESULT},
    '{bnp_pkg::CH_R,     1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_N,     1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_LB,    1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_A,     1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_K,     1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_C,     1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_P,     1'b0, 1'b0, NO_RESULT},
    '{"2",               1'b0, 1'b1, NO_RESULT},
    '{"C",               1'b0, 1'b1, NO_RESULT},   // piece past the last column
    '{8'hFF,             1'b1, 1'b1, STATUS_BAD},
    '{"K",               1'b0, 1'b0, NO_RESULT},
    '{bnp_pkg::CH_NINE,  1'b0, 1'b1, NO_RESULT},   // digit runs off the rank
    '{"R",               1'b0, 1'b1, NO_RESULT},   // ignored after the error
    '{8'h00,             1'b1, 1'b1, STATUS_BAD},
    '{bnp_pkg::CH_SLASH, 1'b1, 1'b1, STATUS_BAD},  // rank closed early
    '{8'h80,             1'b1, 1'b1, STATUS_BAD},  // not a board character
    '{bnp_pkg::CH_NINE,  1'b0, 1'b1, NO_RESULT},
    '{" ",               1'b0, 1'b1, NO_RESULT},   // board ends after one rank
    '{bnp_pkg::CH_W,     1'b1, 1'b1, STATUS_BAD},
    '{bnp_pkg::CH_P,     1'b1, 1'b1, STATUS_BAD}   // last byte inside the board
  };

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  // parser model state
  bnp_pkg::phase_t text_phase  = bnp_pkg::PH_LEAD;
  logic [3:0]      pos_row     = '0;
  logic [3:0]      pos_col     = '0;
  logic            text_failed = 1'b0;
  logic [1:0]      turn_chars  = '0;
  logic            turn_white  = 1'b0;

  bnp_pkg::result_t expected_words[$];
  logic [7:0]       text_bytes[$];
  int               fail_count  = 0;
  int               sent_bytes  = 0;
  int               idle_cycles = 0;
  bit               no_idle     = 1'b0;

  board_notation_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bnp_pkg::result_t parse_byte(input logic [7:0] c, input logic is_last);
    bnp_pkg::result_t r;
    logic       blank;
    logic       placed;
    logic       red;
    logic       ok;
    logic [3:0] prow;
    logic [3:0] pcol;
    logic [2:0] code;
    logic [4:0] nc;
    logic [7:0] lc;
    r      = '0;
    placed = 1'b0;
    red    = 1'b0;
    prow   = '0;
    pcol   = '0;
    code   = '0;
    blank  = is_space(c);
    if (!text_failed) begin
      if (text_phase == bnp_pkg::PH_LEAD && !blank) text_phase = bnp_pkg::PH_BOARD;
      if (text_phase == bnp_pkg::PH_BOARD) begin
        if (blank) begin
          if (pos_row != bnp_pkg::ROW_LAST || pos_col != bnp_pkg::COL_LIMIT) text_failed = 1'b1;
          text_phase = bnp_pkg::PH_GAP;
        end else begin
          prow = pos_row;
          pcol = pos_col;
          if (c == bnp_pkg::CH_SLASH) begin
            if (pos_col != bnp_pkg::COL_LIMIT || pos_row >= bnp_pkg::ROW_LAST) begin
              text_failed = 1'b1;
            end else begin
              pos_row = pos_row + 4'd1;
              pos_col = '0;
            end
          end else if (pos_row >= 4'(bnp_pkg::ROWS)) begin
            text_failed = 1'b1;
          end else if (c >= bnp_pkg::CH_ONE && c <= bnp_pkg::CH_NINE) begin
            nc = 5'(pos_col) + 5'(c - bnp_pkg::CH_ONE) + 5'd1;
            if (nc > 5'(bnp_pkg::COLUMNS)) text_failed = 1'b1;
            else pos_col = nc[3:0];
          end else if (pos_col >= bnp_pkg::COL_LIMIT) begin
            text_failed = 1'b1;
          end else begin
            red    = (c >= bnp_pkg::CH_UP_A && c <= bnp_pkg::CH_UP_Z);
            lc     = red ? c + 8'h20 : c;
            placed = 1'b1;
            case (lc)
              bnp_pkg::CH_R:  code = bnp_pkg::PIECE_CHARIOT;
              bnp_pkg::CH_N:  code = bnp_pkg::PIECE_HORSE;
              bnp_pkg::CH_LB: code = bnp_pkg::PIECE_ELEPHANT;
              bnp_pkg::CH_A:  code = bnp_pkg::PIECE_ADVISOR;
              bnp_pkg::CH_K:  code = bnp_pkg::PIECE_KING;
              bnp_pkg::CH_C:  code = bnp_pkg::PIECE_CANNON;
              bnp_pkg::CH_P:  code = bnp_pkg::PIECE_SOLDIER;
              default:        placed = 1'b0;
            endcase
            if (placed) pos_col = pos_col + 4'd1;
            else text_failed = 1'b1;
          end
        end
      end else if (text_phase == bnp_pkg::PH_GAP && !blank) begin
        text_phase = bnp_pkg::PH_TURN;
      end
      if (text_phase == bnp_pkg::PH_TURN && !text_failed) begin
        if (blank) begin
          text_phase = bnp_pkg::PH_TAIL;
        end else if (turn_chars == 2'd0) begin
          turn_white = (c == bnp_pkg::CH_W);
          if (c != bnp_pkg::CH_W && c != bnp_pkg::CH_B) text_failed = 1'b1;
          turn_chars = 2'd1;
        end else begin
          text_failed = 1'b1;
          turn_chars  = 2'd2;
        end
      end
    end
    if (is_last) begin
      ok            = !text_failed && text_phase >= bnp_pkg::PH_TURN && turn_chars == 2'd1;
      r.has         = 1'b1;
      r.kind        = bnp_pkg::KIND_STATUS;
      r.valid_res   = ok;
      r.red_to_move = ok && turn_white;
      text_phase    = bnp_pkg::PH_LEAD;
      pos_row       = '0;
      pos_col       = '0;
      text_failed   = 1'b0;
      turn_chars    = '0;
      turn_white    = 1'b0;
    end else if (placed && !text_failed) begin
      r.has       = 1'b1;
      r.kind      = bnp_pkg::KIND_PLACE;
      r.rank_row  = prow;
      r.file_col  = pcol;
      r.piece     = code;
      r.piece_red = red;
    end
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic l, input logic typed,
                           input bnp_pkg::result_t fixed);
    bnp_pkg::result_t r;
    while (!no_idle && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    r = parse_byte(c, l);
    if (typed) r = fixed;
    if (r.has) expected_words.insert(expected_words.size(), r);
  endtask

  function automatic logic [7:0] random_blank();
    return ($urandom_range(5) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
  endfunction

  task automatic append_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  // a full board with a side to move, damaged in about four texts of ten
  task automatic make_text();
    int         flaw;
    int         col;
    int         d;
    int         pos;
    logic [7:0] ch;
    flaw = $urandom_range(11);
    text_bytes.delete();
    repeat ($urandom_range(2)) append_byte(random_blank());
    for (int r = 0; r < bnp_pkg::ROWS; r++) begin
      if (r > 0) append_byte(bnp_pkg::CH_SLASH);
      col = 0;
      while (col < bnp_pkg::COLUMNS) begin
        if ($urandom_range(1)) begin
          ch = PIECE_LETTERS[$urandom_range(6)];
          if ($urandom_range(1)) ch = ch - 8'h20;
          append_byte(ch);
          col++;
        end else begin
          d = $urandom_range(bnp_pkg::COLUMNS - col, 1);
          append_byte(bnp_pkg::CH_ONE + 8'(d - 1));
          col += d;
        end
      end
    end
    repeat ($urandom_range(2, 1)) append_byte(random_blank());
    if (flaw == 3) append_byte(8'($urandom_range(255)));
    else append_byte($urandom_range(1) ? bnp_pkg::CH_W : bnp_pkg::CH_B);
    if (flaw == 4) append_byte($urandom_range(1) ? bnp_pkg::CH_W : 8'($urandom_range(255)));
    if ($urandom_range(3) == 0) begin
      append_byte(random_blank());
      repeat ($urandom_range(3, 1)) append_byte(8'($urandom_range(255)));
    end
    pos = $urandom_range(text_bytes.size() - 1);
    case (flaw)
      0: text_bytes[pos] = 8'($urandom_range(255));
      1: text_bytes = text_bytes[0:pos];
      2: begin
        case ($urandom_range(2))
          0:       ch = bnp_pkg::CH_SLASH;
          1:       ch = bnp_pkg::CH_ONE + 8'($urandom_range(8));
          default: ch = PIECE_LETTERS[$urandom_range(6)];
        endcase
        text_bytes.insert(pos, ch);
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin : result_check
    bnp_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, m_tuser[0]);
        check_field("rank_row", want.rank_row, m_tdata[3:0]);
        check_field("file_col", want.file_col, m_tdata[7:4]);
        check_field("piece", want.piece, m_tdata[10:8]);
        check_field("piece_red", want.piece_red, m_tdata[11]);
        check_field("valid_res", want.valid_res, m_tdata[12]);
        check_field("red_to_move", want.red_to_move, m_tdata[13]);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int text_count;
    text_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_byte(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].fixed);
    end
    while (sent_bytes < TARGET_BYTES) begin
      no_idle = (text_count >= 6 && text_count < 10);
      make_text();
      foreach (text_bytes[i]) begin
        send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_RESULT);
      end
      text_count++;
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/bnp_pkg.sv
design/bnp_parser_core.sv
design/board_notation_parser.sv
verif/testbench.sv
